>>> rtl/ocm_pkg.sv
`timescale 1ns / 1ps
package ocm_pkg;

  localparam int X_W = 12;
  localparam int P_W = 16;
  localparam int CFG_W = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_OBJECT_AREA_DEF = 65536;
  localparam int QDEPTH_DEF = 4;

  localparam logic [1:0] CFG_MIN_AREA = 2'd0;
  localparam logic [1:0] CFG_MAX_AREA = 2'd1;
  localparam logic [1:0] CFG_MIN_ASPECT = 2'd2;
  localparam logic [1:0] CFG_MAX_ASPECT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ASPECT = 2'd1;
  localparam logic [1:0] ST_AREA = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] pixel_value;
    logic [15:0] background_level;
    logic        in_object;
    logic        last_pixel;
  } pix_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] centroid_x;
    logic [19:0] centroid_y;
    logic [19:0] sigma_x;
    logic [19:0] sigma_y;
    logic [31:0] intensity_sum;
    logic [16:0] object_area;
  } res_t;

  typedef struct packed {
    logic [16:0] count;
    logic [31:0] wsum;
    logic [43:0] xs;
    logic [43:0] ys;
    logic [55:0] xxs;
    logic [55:0] yys;
    logic [11:0] bx_min;
    logic [11:0] bx_max;
    logic [11:0] by_min;
    logic [11:0] by_max;
  } rec_t;

  typedef struct packed {
    logic [15:0] min_area;
    logic [15:0] max_area;
    logic [15:0] min_aspect;
    logic [15:0] max_aspect;
  } cfg_t;

  localparam rec_t REC_CLR = '{count: '0, wsum: '0, xs: '0, ys: '0, xxs: '0, yys: '0,
                               bx_min: '1, bx_max: '0, by_min: '1, by_max: '0};

  typedef enum logic [3:0] {
    BK_IDLE, BK_CHECK, BK_CLASS, BK_CDIV, BK_MULA, BK_MULB, BK_ROOT, BK_SDIV, BK_DONE
  } bk_state_t;

endpackage

>>> rtl/ocm_front.sv
`timescale 1ns / 1ps
module ocm_front #(
  parameter int COORD_BITS = ocm_pkg::COORD_BITS_DEF,
  parameter int PIXEL_BITS = ocm_pkg::PIXEL_BITS_DEF,
  parameter int MAX_OBJECT_AREA = ocm_pkg::MAX_OBJECT_AREA_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  ocm_pkg::pix_t in_pixel,
  output logic          push,
  output ocm_pkg::rec_t push_rec,
  output logic [1:0]    inflight
);
  import ocm_pkg::*;

  localparam int CB = (COORD_BITS < X_W) ? COORD_BITS : X_W;
  localparam int PB = (PIXEL_BITS < P_W) ? PIXEL_BITS : P_W;
  localparam logic [X_W-1:0] CMASK = X_W'((33'd1 << CB) - 33'd1);
  localparam logic [P_W-1:0] PMASK = P_W'((33'd1 << PB) - 33'd1);
  localparam logic [16:0] ACAP = (MAX_OBJECT_AREA < 131071) ?
                                 17'(MAX_OBJECT_AREA) : 17'd131071;

  logic [X_W-1:0] x_in, y_in;
  logic [P_W-1:0] v_in, bg_in;

  logic           vld1_r, vld2_r;
  logic           mem1_r, mem2_r, wv1_r, wv2_r, last1_r, last2_r;
  logic [X_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [23:0]    xx1_r, yy1_r;
  logic [P_W-1:0] d1_r, d2_r;
  logic [27:0]    xd2_r, yd2_r;
  logic [39:0]    xxd2_r, yyd2_r;
  rec_t           acc_r, acc_nxt;

  logic [32:0] ws_s;
  logic [44:0] xs_s, ys_s;
  logic [56:0] xxs_s, yys_s;

  assign x_in = in_pixel.pixel_x & CMASK;
  assign y_in = in_pixel.pixel_y & CMASK;
  assign v_in = in_pixel.pixel_value & PMASK;
  assign bg_in = in_pixel.background_level & PMASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_fire;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x_in;
    y1_r <= y_in;
    xx1_r <= 24'(x_in) * 24'(x_in);
    yy1_r <= 24'(y_in) * 24'(y_in);
    d1_r <= v_in - bg_in;
    wv1_r <= v_in >= bg_in;
    mem1_r <= in_pixel.in_object;
    last1_r <= in_pixel.last_pixel;
    x2_r <= x1_r;
    y2_r <= y1_r;
    d2_r <= d1_r;
    wv2_r <= wv1_r;
    mem2_r <= mem1_r;
    last2_r <= last1_r;
    xd2_r <= 28'(x1_r) * 28'(d1_r);
    yd2_r <= 28'(y1_r) * 28'(d1_r);
    xxd2_r <= 40'(xx1_r) * 40'(d1_r);
    yyd2_r <= 40'(yy1_r) * 40'(d1_r);
  end

  assign ws_s = {1'b0, acc_r.wsum} + 33'(d2_r);
  assign xs_s = {1'b0, acc_r.xs} + 45'(xd2_r);
  assign ys_s = {1'b0, acc_r.ys} + 45'(yd2_r);
  assign xxs_s = {1'b0, acc_r.xxs} + 57'(xxd2_r);
  assign yys_s = {1'b0, acc_r.yys} + 57'(yyd2_r);

  always_comb begin
    acc_nxt = acc_r;
    if (mem2_r) begin
      if (acc_r.count < ACAP) acc_nxt.count = acc_r.count + 17'd1;
      if (x2_r < acc_r.bx_min) acc_nxt.bx_min = x2_r;
      if (x2_r > acc_r.bx_max) acc_nxt.bx_max = x2_r;
      if (y2_r < acc_r.by_min) acc_nxt.by_min = y2_r;
      if (y2_r > acc_r.by_max) acc_nxt.by_max = y2_r;
      if (wv2_r) begin
        acc_nxt.wsum = ws_s[32] ? '1 : ws_s[31:0];
        acc_nxt.xs = xs_s[44] ? '1 : xs_s[43:0];
        acc_nxt.ys = ys_s[44] ? '1 : ys_s[43:0];
        acc_nxt.xxs = xxs_s[56] ? '1 : xxs_s[55:0];
        acc_nxt.yys = yys_s[56] ? '1 : yys_s[55:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= REC_CLR;
    end else if (vld2_r) begin
      acc_r <= last2_r ? REC_CLR : acc_nxt;
    end
  end

  assign push = vld2_r & last2_r;
  assign push_rec = acc_nxt;
  assign inflight = 2'(vld1_r & last1_r) + 2'(vld2_r & last2_r);

endmodule

>>> rtl/ocm_queue.sv
`timescale 1ns / 1ps
module ocm_queue #(
  parameter int DEPTH = ocm_pkg::QDEPTH_DEF,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ocm_pkg::rec_t push_rec,
  input  logic          pop,
  output ocm_pkg::rec_t head,
  output logic          empty,
  output logic [CW-1:0] count
);
  import ocm_pkg::*;

  localparam int PW = $clog2(DEPTH);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop) rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  assign head = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CW'(DEPTH)) || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue underflow");

endmodule

>>> rtl/ocm_back.sv
`timescale 1ns / 1ps
module ocm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ocm_pkg::cfg_t cfg,
  input  ocm_pkg::rec_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  output ocm_pkg::res_t out_result
);
  import ocm_pkg::*;

  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [5:0] MUL_LAST = 6'd43;
  localparam logic [5:0] ROOT_LAST = 6'd51;

  bk_state_t   st_r, st_nxt;
  logic        ax_r, emit;
  logic [5:0]  cnt_r;
  rec_t        rec_r;
  logic [1:0]  status_r, status_c;
  logic [19:0] cx_r, cy_r, sx_r, sy_r;
  logic [27:0] lo_r, hi_r;
  logic [19:0] wq_r;
  logic        hz_r;
  logic [11:0] bw, bh;

  logic [87:0]  mp_r, mc_r, a_r, mp_n;
  logic [43:0]  ml_r;
  logic [103:0] sn_r;
  logic [55:0]  srem_r, sq_t, sq_trial, srem_n;
  logic [51:0]  root_r, root_n;
  logic         sq_ge;
  logic [63:0]  dnum_r, dq_r, dq_n, q_rnd;
  logic [32:0]  drem_r, d_try, drem_n;
  logic         d_ge, rnd, m_le;
  logic [31:0]  wsum, thr;
  logic [19:0]  q_sat, qr_sat;
  logic [63:0]  cnum_x, cnum_y;
  logic         div_end, mul_end, root_end;
  logic         out_valid_r;
  res_t         out_r;

  assign wsum = rec_r.wsum;
  assign thr = wsum - (wsum >> 1);
  assign cnum_x = {12'b0, rec_r.xs, 8'b0} + {32'b0, wsum >> 1};
  assign cnum_y = {12'b0, rec_r.ys, 8'b0} + {32'b0, wsum >> 1};

  assign d_try = {drem_r[31:0], dnum_r[63]};
  assign d_ge = d_try >= {1'b0, wsum};
  assign drem_n = d_ge ? d_try - {1'b0, wsum} : d_try;
  assign dq_n = {dq_r[62:0], d_ge};
  assign q_sat = (|dq_n[63:20]) ? '1 : dq_n[19:0];
  assign rnd = drem_n[31:0] >= thr;
  assign q_rnd = dq_n + 64'(rnd);
  assign qr_sat = (|q_rnd[63:20]) ? '1 : q_rnd[19:0];

  assign mp_n = mp_r + (ml_r[0] ? mc_r : '0);
  assign m_le = a_r <= mp_n;

  assign sq_t = {srem_r[53:0], sn_r[103:102]};
  assign sq_trial = {2'b0, root_r, 2'b01};
  assign sq_ge = sq_t >= sq_trial;
  assign srem_n = sq_ge ? sq_t - sq_trial : sq_t;
  assign root_n = {root_r[50:0], sq_ge};

  assign div_end = cnt_r == DIV_LAST;
  assign mul_end = cnt_r == MUL_LAST;
  assign root_end = cnt_r == ROOT_LAST;

  assign bw = (rec_r.count == '0) ? '0 : rec_r.bx_max - rec_r.bx_min;
  assign bh = (rec_r.count == '0) ? '0 : rec_r.by_max - rec_r.by_min;

  always_comb begin
    if (hz_r || (28'(wq_r) < lo_r) || (28'(wq_r) > hi_r)) begin
      status_c = ST_ASPECT;
    end else if ((rec_r.count < 17'(cfg.min_area)) || (rec_r.count > 17'(cfg.max_area))) begin
      status_c = ST_AREA;
    end else if (wsum == '0) begin
      status_c = ST_ZERO;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:  if (!empty) st_nxt = BK_CHECK;
      BK_CHECK: st_nxt = BK_CLASS;
      BK_CLASS: st_nxt = (status_c == ST_OK) ? BK_CDIV : BK_DONE;
      BK_CDIV:  if (div_end && ax_r) st_nxt = BK_MULA;
      BK_MULA:  if (mul_end) st_nxt = BK_MULB;
      BK_MULB: begin
        if (mul_end) begin
          if (!m_le) st_nxt = BK_ROOT;
          else st_nxt = ax_r ? BK_DONE : BK_MULA;
        end
      end
      BK_ROOT:  if (root_end) st_nxt = BK_SDIV;
      BK_SDIV:  if (div_end) st_nxt = ax_r ? BK_DONE : BK_MULA;
      BK_DONE:  st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = (st_r == BK_IDLE) && !empty;
    emit = (st_r == BK_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_r + 6'd1;
    unique case (st_r)
      BK_IDLE: begin
        rec_r <= head;
        ax_r <= 1'b0;
      end
      BK_CHECK: begin
        lo_r <= 28'(cfg.min_aspect) * 28'(bh);
        hi_r <= 28'(cfg.max_aspect) * 28'(bh);
        wq_r <= {bw, 8'b0};
        hz_r <= bh == '0;
      end
      BK_CLASS: begin
        status_r <= status_c;
        cx_r <= '0;
        cy_r <= '0;
        sx_r <= '0;
        sy_r <= '0;
        dnum_r <= cnum_x;
        drem_r <= '0;
        dq_r <= '0;
        cnt_r <= '0;
      end
      BK_CDIV: begin
        dnum_r <= dnum_r << 1;
        drem_r <= drem_n;
        dq_r <= dq_n;
        if (div_end) begin
          cnt_r <= '0;
          drem_r <= '0;
          dq_r <= '0;
          if (!ax_r) begin
            cx_r <= q_sat;
            dnum_r <= cnum_y;
            ax_r <= 1'b1;
          end else begin
            cy_r <= q_sat;
            ax_r <= 1'b0;
            mp_r <= '0;
            mc_r <= {32'b0, rec_r.xxs};
            ml_r <= {12'b0, wsum};
          end
        end
      end
      BK_MULA: begin
        mp_r <= mp_n;
        mc_r <= mc_r << 1;
        ml_r <= ml_r >> 1;
        if (mul_end) begin
          a_r <= mp_n;
          mp_r <= '0;
          mc_r <= {44'b0, ax_r ? rec_r.ys : rec_r.xs};
          ml_r <= ax_r ? rec_r.ys : rec_r.xs;
          cnt_r <= '0;
        end
      end
      BK_MULB: begin
        mp_r <= mp_n;
        mc_r <= mc_r << 1;
        ml_r <= ml_r >> 1;
        if (mul_end) begin
          cnt_r <= '0;
          sn_r <= {a_r - mp_n, 16'b0};
          srem_r <= '0;
          root_r <= '0;
          if (m_le && !ax_r) begin
            ax_r <= 1'b1;
            mp_r <= '0;
            mc_r <= {32'b0, rec_r.yys};
            ml_r <= {12'b0, wsum};
          end
        end
      end
      BK_ROOT: begin
        sn_r <= sn_r << 2;
        srem_r <= srem_n;
        root_r <= root_n;
        if (root_end) begin
          cnt_r <= '0;
          dnum_r <= {12'b0, root_n};
          drem_r <= '0;
          dq_r <= '0;
        end
      end
      BK_SDIV: begin
        dnum_r <= dnum_r << 1;
        drem_r <= drem_n;
        dq_r <= dq_n;
        if (div_end) begin
          cnt_r <= '0;
          if (!ax_r) begin
            sx_r <= qr_sat;
            ax_r <= 1'b1;
            mp_r <= '0;
            mc_r <= {32'b0, rec_r.yys};
            ml_r <= {12'b0, wsum};
          end else begin
            sy_r <= qr_sat;
          end
        end
      end
      BK_DONE: begin
        out_r.status <= status_r;
        out_r.centroid_x <= cx_r;
        out_r.centroid_y <= cy_r;
        out_r.sigma_x <= sx_r;
        out_r.sigma_y <= sy_r;
        out_r.intensity_sum <= wsum;
        out_r.object_area <= rec_r.count;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_result = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> st_r == BK_CHECK) else $error("pop outside idle");

endmodule

>>> rtl/object_centroid_moments.sv
`timescale 1ns / 1ps
// Pixels are taken one per cycle unless busy; busy rises only when the object queue could fill.
// With the back end idle, a rejected or zero-intensity object goes from the check and classify
// states straight to its result; an accepted one also runs the centroid divides and, per axis,
// shift-add multiplies and, unless the variance is zero, a square root and the shared divider.
// Synchronous active-low reset clears accumulators and queue and sets the limits wide open.
module object_centroid_moments #(
  parameter int COORD_BITS = ocm_pkg::COORD_BITS_DEF,
  parameter int PIXEL_BITS = ocm_pkg::PIXEL_BITS_DEF,
  parameter int MAX_OBJECT_AREA = ocm_pkg::MAX_OBJECT_AREA_DEF,
  parameter int QUEUE_DEPTH = ocm_pkg::QDEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ocm_pkg::pix_t in_pixel,
  output logic          out_valid,
  output ocm_pkg::res_t out_result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import ocm_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg_r;
  logic          in_fire, push, pop, q_empty;
  rec_t          push_rec, head;
  logic [1:0]    inflight;
  logic [CW-1:0] q_count;
  logic [CW:0]   pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_area <= '0;
      cfg_r.max_area <= '1;
      cfg_r.min_aspect <= '0;
      cfg_r.max_aspect <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_AREA:   cfg_r.min_area <= cfg_data;
        CFG_MAX_AREA:   cfg_r.max_area <= cfg_data;
        CFG_MIN_ASPECT: cfg_r.min_aspect <= cfg_data;
        CFG_MAX_ASPECT: cfg_r.max_aspect <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pending = (CW + 1)'(q_count) + (CW + 1)'(inflight);
  assign busy = pending >= (CW + 1)'(QUEUE_DEPTH);
  assign in_fire = start && !busy;

  ocm_front #(
    .COORD_BITS(COORD_BITS),
    .PIXEL_BITS(PIXEL_BITS),
    .MAX_OBJECT_AREA(MAX_OBJECT_AREA)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_fire(in_fire),
    .in_pixel(in_pixel),
    .push(push),
    .push_rec(push_rec),
    .inflight(inflight)
  );

  ocm_queue #(
    .DEPTH(QUEUE_DEPTH),
    .CW(CW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_rec(push_rec),
    .pop(pop),
    .head(head),
    .empty(q_empty),
    .count(q_count)
  );

  ocm_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .head(head),
    .empty(q_empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_result(out_result)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import ocm_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 1800;

  class CentroidScoreboard;
    cfg_t regs;
    longint unsigned count, wsum, xs, ys, xxs, yys;
    logic [11:0] bx_min, bx_max, by_min, by_max;
    res_t objects_due[$];
    int errors;
    int checked;
    int status_seen[4];

    function new();
      regs = '{min_area: 16'd0, max_area: 16'hFFFF, min_aspect: 16'd0, max_aspect: 16'hFFFF};
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_acc();
    endfunction

    function void clear_acc();
      count = 0; wsum = 0; xs = 0; ys = 0; xxs = 0; yys = 0;
      bx_min = '1; by_min = '1; bx_max = '0; by_max = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] d);
      case (idx)
        CFG_MIN_AREA: regs.min_area = d;
        CFG_MAX_AREA: regs.max_area = d;
        CFG_MIN_ASPECT: regs.min_aspect = d;
        CFG_MAX_ASPECT: regs.max_aspect = d;
      endcase
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                      longint unsigned top);
      return (a + b > top) ? top : a + b;
    endfunction

    function logic [63:0] root_of(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    function logic [19:0] spread_of(longint unsigned w, longint unsigned s1,
                                    longint unsigned s2);
      logic [127:0] a, b, n;
      logic [63:0] rt;
      longint unsigned q;
      a = 128'(w) * 128'(s2);
      b = 128'(s1) * 128'(s1);
      if (a <= b) return '0;
      n = (a - b) << 16;
      rt = root_of(n);
      q = rt / w + (((rt % w) >= (w - w / 2)) ? 1 : 0);
      return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
    endfunction

    function logic [19:0] mean_of(longint unsigned w, longint unsigned s1);
      longint unsigned q;
      q = (s1 * 256 + w / 2) / w;
      return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
    endfunction

    function void note_pixel(pix_t p);
      longint unsigned d, x, y, bw, bh;
      res_t r;
      x = p.pixel_x;
      y = p.pixel_y;
      if (p.in_object) begin
        if (count < 65536) count++;
        if (p.pixel_x < bx_min) bx_min = p.pixel_x;
        if (p.pixel_x > bx_max) bx_max = p.pixel_x;
        if (p.pixel_y < by_min) by_min = p.pixel_y;
        if (p.pixel_y > by_max) by_max = p.pixel_y;
        if (p.pixel_value >= p.background_level) begin
          d = p.pixel_value - p.background_level;
          wsum = sat_sum(wsum, d, 64'hFFFFFFFF);
          xs = sat_sum(xs, x * d, 64'hFFFFFFFFFFF);
          ys = sat_sum(ys, y * d, 64'hFFFFFFFFFFF);
          xxs = sat_sum(xxs, x * x * d, 64'hFFFFFFFFFFFFFF);
          yys = sat_sum(yys, y * y * d, 64'hFFFFFFFFFFFFFF);
        end
      end
      if (!p.last_pixel) return;
      if (count == 0) begin
        bw = 0; bh = 0;
      end else begin
        bw = bx_max - bx_min; bh = by_max - by_min;
      end
      r = '0;
      if (bh == 0 || bw * 256 < regs.min_aspect * bh || bw * 256 > regs.max_aspect * bh) begin
        r.status = ST_ASPECT;
      end else if (count < regs.min_area || count > regs.max_area) begin
        r.status = ST_AREA;
      end else if (wsum == 0) begin
        r.status = ST_ZERO;
      end else begin
        r.status = ST_OK;
        r.centroid_x = mean_of(wsum, xs);
        r.centroid_y = mean_of(wsum, ys);
        r.sigma_x = spread_of(wsum, xs, xxs);
        r.sigma_y = spread_of(wsum, ys, yys);
      end
      r.intensity_sum = wsum[31:0];
      r.object_area = count[16:0];
      objects_due.push_back(r);
      clear_acc();
    endfunction

    function void cmp_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (objects_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, a);
        return;
      end
      e = objects_due.pop_front();
      checked++;
      status_seen[e.status]++;
      cmp_field("status", e.status, a.status);
      cmp_field("centroid_x", e.centroid_x, a.centroid_x);
      cmp_field("centroid_y", e.centroid_y, a.centroid_y);
      cmp_field("sigma_x", e.sigma_x, a.sigma_x);
      cmp_field("sigma_y", e.sigma_y, a.sigma_y);
      cmp_field("intensity_sum", e.intensity_sum, a.intensity_sum);
      cmp_field("object_area", e.object_area, a.object_area);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pix_t in_pixel;
  logic out_valid;
  res_t out_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  CentroidScoreboard sb;
  int cyc;
  int pixels_sent;
  int idle_pct;

  object_centroid_moments uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_result(out_result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result);
  end

  task automatic send_pixel(pix_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.objects_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic send_box(int x0, int y0, int wd, int ht, int member_pct,
                          int vmin, int vmax, int bg);
    pix_t p;
    for (int j = 0; j < ht; j++) begin
      for (int i = 0; i < wd; i++) begin
        p.pixel_x = 12'(x0 + i);
        p.pixel_y = 12'(y0 + j);
        p.pixel_value = 16'($urandom_range(vmax, vmin));
        p.background_level = 16'(bg);
        p.in_object = ($urandom_range(99) < member_pct);
        p.last_pixel = (i == wd - 1) && (j == ht - 1);
        send_pixel(p);
      end
    end
  endtask

  task automatic random_object();
    int wd, ht, x0, y0, bg;
    pix_t p;
    logic [63:0] raw;
    if ($urandom_range(99) < 15) begin
      raw = {$urandom, $urandom};
      p = pix_t'(raw[$bits(pix_t)-1:0]);
      p.last_pixel = ($urandom_range(3) == 0);
      send_pixel(p);
      return;
    end
    if ($urandom_range(9) == 0) begin
      wd = $urandom_range(20, 1);
      ht = $urandom_range(20, 1);
    end else begin
      wd = $urandom_range(6, 1);
      ht = $urandom_range(6, 1);
    end
    x0 = $urandom_range(4096 - wd);
    y0 = $urandom_range(4096 - ht);
    bg = $urandom_range(65535);
    if ($urandom_range(3) == 0)
      send_box(x0, y0, wd, ht, 80, 0, 65535, bg);
    else
      send_box(x0, y0, wd, ht, 85, bg, (bg + 2000 > 65535) ? 65535 : bg + 2000, bg);
  endtask

  task automatic random_phase(int items, int idle);
    int stop_at;
    idle_pct = idle;
    stop_at = pixels_sent + items;
    while (pixels_sent < stop_at) random_object();
    drain();
  endtask

  initial begin
    sb = new();
    cyc = 0;
    pixels_sent = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_AREA;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_box(0, 0, 2, 2, 100, 65535, 65535, 0);
    send_box(4094, 4094, 2, 2, 100, 0, 65535, 0);
    send_box(10, 20, 1, 1, 0, 5, 5, 0);
    send_box(100, 50, 4, 1, 100, 300, 900, 10);
    send_box(7, 9, 2, 3, 100, 1000, 1000, 1000);
    send_box(7, 9, 2, 3, 100, 0, 999, 1000);
    send_box(300, 40, 3, 2, 100, 0, 65535, 30000);
    send_box(0, 4000, 3, 3, 60, 40000, 65535, 39000);
    drain();
    write_reg(CFG_MIN_AREA, 16'hFFFF);
    write_reg(CFG_MAX_ASPECT, 16'h0000);
    send_box(50, 50, 2, 2, 100, 500, 600, 0);
    drain();
    write_reg(CFG_MAX_ASPECT, 16'hFFFF);
    send_box(50, 50, 2, 2, 100, 500, 600, 0);
    drain();
    write_reg(CFG_MIN_AREA, 16'd0);
    write_reg(CFG_MAX_AREA, 16'd0);
    write_reg(CFG_MIN_ASPECT, 16'hFFFF);
    send_box(60, 60, 2, 2, 100, 500, 600, 0);
    drain();
    write_reg(CFG_MIN_ASPECT, 16'd0);
    send_box(60, 60, 2, 2, 100, 500, 600, 0);
    drain();
    write_reg(CFG_MAX_AREA, 16'hFFFF);

    random_phase(RANDOM_ITEMS / 3, 25);
    write_reg(CFG_MIN_AREA, 16'($urandom_range(6)));
    write_reg(CFG_MAX_AREA, 16'($urandom_range(40, 8)));
    write_reg(CFG_MIN_ASPECT, 16'($urandom_range(128)));
    write_reg(CFG_MAX_ASPECT, 16'($urandom_range(1024, 256)));
    random_phase(RANDOM_ITEMS / 3, 83);
    write_reg(CFG_MIN_AREA, 16'd0);
    write_reg(CFG_MAX_AREA, 16'hFFFF);
    write_reg(CFG_MIN_ASPECT, 16'd0);
    write_reg(CFG_MAX_ASPECT, 16'hFFFF);
    random_phase(RANDOM_ITEMS / 3, 0);
    repeat (50) @(posedge clk);

    $display("Sent %0d pixels and checked %0d objects.", pixels_sent, sb.checked);
    $display("Status counts: accepted %0d, aspect %0d, area %0d, zero intensity %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_ASPECT], sb.status_seen[ST_AREA],
             sb.status_seen[ST_ZERO]);
    if (sb.errors == 0 && sb.objects_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> object_centroid_moments.f
rtl/ocm_pkg.sv
rtl/ocm_front.sv
rtl/ocm_queue.sv
rtl/ocm_back.sv
rtl/object_centroid_moments.sv
test/tb.sv
